@@ sv/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the record stream deframer
// Message layout constants, status codes, register indexes and the
// structs that travel between the deframer's submodules.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int unsigned RSD_HDR_LEN      = 8;
  localparam int unsigned RSD_REC_LEN      = 13;
  localparam int unsigned RSD_REC_STATE_AT = 12;
  localparam int unsigned RSD_FIELD_LEN    = 4;
  localparam int unsigned RSD_QUEUE_DEPTH  = 4;

  // tdata: player_id, entity_id, state_code, status packed, padded to bytes
  localparam int unsigned RSD_OUT_FIELDS_W = 32 + 64 + 8 + 2;
  localparam int unsigned RSD_OUT_DATA_W   = ((RSD_OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [3:0] RSD_HDR_BODY = 4'(RSD_HDR_LEN);
  localparam logic [3:0] RSD_HDR_LAST = 4'(RSD_HDR_LEN - 1);
  localparam logic [3:0] RSD_REC_LAST = 4'(RSD_REC_LEN - 1);
  localparam logic [3:0] RSD_REC_STATE = 4'(RSD_REC_STATE_AT);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_EXPECTED_SCHEMA  = 2'd0,
    REG_MAX_RECORD_COUNT = 2'd1,
    REG_HIGHEST_STATE    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [31:0] expected_schema;
    logic [31:0] max_record_count;
    logic [7:0]  highest_state_code;
  } cfg_t;

  // One queue entry holds everything a single byte produces
  typedef struct packed {
    logic        rec_valid;
    logic [31:0] player_id;
    logic [63:0] entity_id;
    logic [7:0]  state_code;
    logic        stat_valid;
    status_e     status;
  } entry_t;

endpackage

@@ sv/rsd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rsd_cfg_regs: configuration register file
// APB-style slave holding the expected schema, the record count limit and
// the highest legal state code.
// ----------------------------------------------------------------------------
module rsd_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output rsd_pkg::cfg_t cfg_o
);
  import rsd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_schema    <= 32'd1;
      cfg_q.max_record_count   <= 32'd65536;
      cfg_q.highest_state_code <= 8'd2;
    end else if (wr_en) begin
      unique case (idx)
        REG_EXPECTED_SCHEMA:  cfg_q.expected_schema    <= pwdata;
        REG_MAX_RECORD_COUNT: cfg_q.max_record_count   <= pwdata;
        REG_HIGHEST_STATE:    cfg_q.highest_state_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EXPECTED_SCHEMA:  prdata = cfg_q.expected_schema;
      REG_MAX_RECORD_COUNT: prdata = cfg_q.max_record_count;
      REG_HIGHEST_STATE:    prdata = {24'd0, cfg_q.highest_state_code};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/rsd_parser.sv @@
// ----------------------------------------------------------------------------
// rsd_parser: per-byte message parser
// Assembles the header and the record fields, checks them and builds a queue
// entry (record and/or status) for each byte ending a record or the message.
// ----------------------------------------------------------------------------
module rsd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rsd_pkg::cfg_t  cfg_i,
  input  logic           in_fire_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_buffer_i,
  output rsd_pkg::entry_t entry_o,
  output logic           push_o
);
  import rsd_pkg::*;

  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [3:0]  rec_off_q, rec_off_d;
  logic [31:0] done_q, done_nx;
  logic        err_q, err_nx;
  logic [31:0] schema_q, schema_d;
  logic [31:0] count_q, count_d;
  logic [7:0]  rec_bytes_q [RSD_REC_STATE_AT];
  logic [7:0]  rec_bytes_d [RSD_REC_STATE_AT];
  logic        in_hdr;
  logic        emit;
  status_e     status;

  assign in_hdr = (hdr_pos_q < RSD_HDR_BODY);

  always_comb begin
    schema_d    = schema_q;
    count_d     = count_q;
    rec_bytes_d = rec_bytes_q;
    done_nx     = done_q;
    err_nx      = err_q;
    emit        = 1'b0;
    rec_off_d   = rec_off_q;
    hdr_pos_d   = hdr_pos_q;

    if (in_hdr) begin
      for (int k = 0; k < RSD_FIELD_LEN; k++) begin
        if (hdr_pos_q[1:0] == 2'(k)) begin
          if (!hdr_pos_q[2]) schema_d[8*k +: 8] = data_byte_i;
          else               count_d[8*k +: 8]  = data_byte_i;
        end
      end
      if (hdr_pos_q == RSD_HDR_LAST &&
          (schema_d != cfg_i.expected_schema || count_d > cfg_i.max_record_count)) begin
        err_nx = 1'b1;
      end
      hdr_pos_d = hdr_pos_q + 4'd1;
    end else begin
      // record offset runs on every body byte
      rec_off_d = (rec_off_q == RSD_REC_LAST) ? 4'd0 : rec_off_q + 4'd1;
      if (!err_q) begin
        if (done_q >= count_q) begin
          err_nx = 1'b1;
        end else if (rec_off_q < RSD_REC_STATE) begin
          for (int k = 0; k < RSD_REC_STATE_AT; k++) begin
            if (rec_off_q == 4'(k)) rec_bytes_d[k] = data_byte_i;
          end
        end else if (data_byte_i > cfg_i.highest_state_code) begin
          err_nx = 1'b1;
        end else begin
          emit    = 1'b1;
          done_nx = done_q + 32'd1;
        end
      end
    end

    if (hdr_pos_q < RSD_HDR_LAST)             status = ST_SHORT;
    else if (err_nx || done_nx != count_d)     status = ST_BAD;
    else                                       status = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= 4'd0;
      rec_off_q <= 4'd0;
      done_q    <= 32'd0;
      err_q     <= 1'b0;
    end else if (in_fire_i) begin
      if (end_of_buffer_i) begin
        // message closes: clear the header position, record offset, count and error
        hdr_pos_q <= 4'd0;
        rec_off_q <= 4'd0;
        done_q    <= 32'd0;
        err_q     <= 1'b0;
      end else begin
        hdr_pos_q <= hdr_pos_d;
        rec_off_q <= rec_off_d;
        done_q    <= done_nx;
        err_q     <= err_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      schema_q    <= schema_d;
      count_q     <= count_d;
      rec_bytes_q <= rec_bytes_d;
    end
  end

  always_comb begin
    entry_o.rec_valid  = emit;
    entry_o.player_id  = {rec_bytes_q[3], rec_bytes_q[2], rec_bytes_q[1], rec_bytes_q[0]};
    entry_o.entity_id  = {rec_bytes_q[11], rec_bytes_q[10], rec_bytes_q[9], rec_bytes_q[8],
                          rec_bytes_q[7], rec_bytes_q[6], rec_bytes_q[5], rec_bytes_q[4]};
    entry_o.state_code = data_byte_i;
    entry_o.stat_valid = end_of_buffer_i;
    entry_o.status     = status;
  end

  assign push_o = in_fire_i & (emit | end_of_buffer_i);

  a_rec_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_off_q <= RSD_REC_LAST)
    else $error("record offset out of range");

  a_no_record_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && in_hdr |-> !emit)
    else $error("record emitted during header");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && end_of_buffer_i |=> hdr_pos_q == 4'd0 && done_q == 32'd0 && !err_q)
    else $error("message state not cleared at end");

endmodule

@@ sv/rsd_out_queue.sv @@
// ----------------------------------------------------------------------------
// rsd_out_queue: result queue and output serializer
// Buffers parser entries and hands out the record and/or the status of each
// entry, the record first, as separate words on the output stream.
// ----------------------------------------------------------------------------
module rsd_out_queue #(
  parameter int unsigned DEPTH = rsd_pkg::RSD_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rsd_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output rsd_pkg::kind_e  kind_o,
  output logic [31:0]     player_id_o,
  output logic [63:0]     entity_id_o,
  output logic [7:0]      state_code_o,
  output rsd_pkg::status_e status_o,
  output logic            last_o
);
  import rsd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             phase_q;
  entry_t           head;
  logic             show_rec;
  logic             fire, final_part, pop;

  assign head       = mem[rd_ptr_q];
  assign show_rec   = head.rec_valid & ~phase_q;
  assign valid_o    = (count_q != '0);
  assign full_o     = (count_q == CNT_FULL);
  assign fire       = valid_o & ready_i;
  assign final_part = ~show_rec | ~head.stat_valid;
  assign pop        = fire & final_part;

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      phase_q  <= 1'b0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      if (pop)    rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      if (push_i && !pop)      count_q <= count_q + CNT_W'(1);
      else if (!push_i && pop) count_q <= count_q - CNT_W'(1);
      // hold the entry after its record goes out, status follows
      if (fire) phase_q <= ~final_part;
    end
  end

  always_comb begin
    kind_o       = show_rec ? KIND_RECORD : KIND_STATUS;
    player_id_o  = show_rec ? head.player_id  : 32'd0;
    entity_id_o  = show_rec ? head.entity_id  : 64'd0;
    state_code_o = show_rec ? head.state_code : 8'd0;
    status_o     = show_rec ? ST_OK : head.status;
    last_o       = ~show_rec;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count above depth");

  a_phase_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> valid_o && head.rec_valid && head.stat_valid)
    else $error("status phase without a pending entry");

  a_split_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !final_part |=> phase_q && $stable(rd_ptr_q))
    else $error("head advanced before its status went out");

endmodule

@@ sv/record_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// record_stream_deframer: byte-stream message deframer
// A result word is written into the output queue when its last byte is taken.
// Throughput: one byte per cycle while the queue is not full; a byte ending a
// record and the message gives two words; its queue entry stays until both go.
// The queue of QUEUE_DEPTH entries sets how far output stalls are absorbed.
// Reset clears the message state and the queue; registers return to defaults.
// ----------------------------------------------------------------------------
module record_stream_deframer #(
  parameter int unsigned QUEUE_DEPTH = rsd_pkg::RSD_QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_buffer
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] player_id, [95:32] entity_id, [103:96] state_code,
  // [105:104] status, [111:106] zero
  output logic [rsd_pkg::RSD_OUT_DATA_W-1:0] m_axis_tdata,
  output logic         m_axis_tuser,   // [0] result_kind
  output logic         m_axis_tlast    // last
);
  import rsd_pkg::*;

  cfg_t        cfg;
  entry_t      entry;
  logic        push, full, in_fire;
  kind_e       kind;
  status_e     status;
  logic [31:0] player_id;
  logic [63:0] entity_id;
  logic [7:0]  state_code;

  assign s_axis_tready = ~full;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  rsd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rsd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_fire_i       (in_fire),
    .data_byte_i     (s_axis_tdata),
    .end_of_buffer_i (s_axis_tlast),
    .entry_o         (entry),
    .push_o          (push)
  );

  rsd_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .kind_o       (kind),
    .player_id_o  (player_id),
    .entity_id_o  (entity_id),
    .state_code_o (state_code),
    .status_o     (status),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {(RSD_OUT_DATA_W - RSD_OUT_FIELDS_W)'(0),
                         status, state_code, entity_id, player_id};

endmodule

@@ tb/sv/record_stream_deframer_test.sv @@
// ----------------------------------------------------------------------------
// record_stream_deframer_test: self-checking bench for the byte deframer
// Streams whole messages into the deframer, predicts every record and status
// word from its own model of the header/record layout, and compares each
// output word field by field. Runs directed corner messages, register access,
// a sweep of register settings, a long output stall and several idling mixes.
// ----------------------------------------------------------------------------
module record_stream_deframer_test;
  import rsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic [7:0] byte_stream_t[$];

  typedef struct {
    kind_e       kind;
    logic [31:0] player;
    logic [63:0] entity;
    logic [7:0]  state;
    status_e     status;
    logic        last;
  } deframed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;  // end_of_buffer

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] player_id, [95:32] entity_id, [103:96] state_code, [105:104] status
  logic [RSD_OUT_DATA_W-1:0] m_axis_tdata;
  logic        m_axis_tuser;         // [0] result_kind
  logic        m_axis_tlast;         // last

  // register copies and message state of the prediction
  logic [31:0] cfg_schema = 32'd1;
  logic [31:0] cfg_max = 32'd65536;
  logic [7:0]  cfg_hsc = 8'd2;
  logic [36:0] msg_pos = '0;
  logic [31:0] hdr_schema = '0;
  logic [31:0] hdr_count = '0;
  logic [95:0] rec_buf = '0;
  logic [31:0] recs_done = '0;
  status_e     msg_err = ST_OK;

  deframed_t pending_words[$];

  int mismatches = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int words_seen = 0;
  int records_seen = 0;
  int status_tally[3] = '{0, 0, 0};
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;

  record_stream_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("record_stream_deframer_test: done, errors");
      $finish;
    end
  end

  // receiver: a long hold-off takes priority over random stalls
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    deframed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected: tdata %0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("result_kind", want.kind, m_axis_tuser);
        check_field("player_id", want.player, m_axis_tdata[31:0]);
        check_field("entity_id", want.entity, m_axis_tdata[95:32]);
        check_field("state_code", want.state, m_axis_tdata[103:96]);
        check_field("status", want.status, m_axis_tdata[105:104]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  function automatic void expect_word(input deframed_t d);
    pending_words.insert(pending_words.size(), d);
  endfunction

  function automatic void restart_message();
    msg_pos = '0;
    hdr_schema = '0;
    hdr_count = '0;
    rec_buf = '0;
    recs_done = '0;
    msg_err = ST_OK;
  endfunction

  // advance the deframing model by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b, input logic eob);
    logic [36:0] pos;
    int r;
    deframed_t d;
    pos = msg_pos;
    if (pos < RSD_HDR_LEN) begin
      if (pos < RSD_FIELD_LEN) hdr_schema[8*int'(pos[1:0]) +: 8] = b;
      else hdr_count[8*int'(pos[1:0]) +: 8] = b;
      if (pos == RSD_HDR_LEN - 1 && (hdr_schema != cfg_schema || hdr_count > cfg_max))
        msg_err = ST_BAD;
    end else if (msg_err == ST_OK) begin
      if (recs_done >= hdr_count) begin
        msg_err = ST_BAD;
      end else begin
        r = int'((pos - RSD_HDR_LEN) % RSD_REC_LEN);
        if (r < RSD_REC_STATE_AT) begin
          rec_buf[8*r +: 8] = b;
        end else if (b > cfg_hsc) begin
          msg_err = ST_BAD;
        end else begin
          d = '{KIND_RECORD, rec_buf[31:0], rec_buf[95:32], b, ST_OK, 1'b0};
          expect_word(d);
          records_seen++;
          recs_done++;
        end
      end
    end
    if (eob) begin
      d = '{KIND_STATUS, '0, '0, '0, ST_OK, 1'b1};
      if (pos < RSD_HDR_LEN - 1) d.status = ST_SHORT;
      else if (msg_err != ST_OK || recs_done != hdr_count) d.status = ST_BAD;
      expect_word(d);
      status_tally[d.status]++;
      msgs_sent++;
      restart_message();
    end else if (pos != '1) begin
      msg_pos = pos + 1;
    end
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_EXPECTED_SCHEMA:  cfg_schema = val;
      REG_MAX_RECORD_COUNT: cfg_max = val;
      REG_HIGHEST_STATE:    cfg_hsc = val[7:0];
      default: ;
    endcase
  endtask

  task automatic reg_read(input reg_idx_e idx, output logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config(input logic [31:0] schema, input logic [31:0] max_count,
                              input logic [7:0] hsc);
    reg_write(REG_EXPECTED_SCHEMA, schema);
    reg_write(REG_MAX_RECORD_COUNT, max_count);
    reg_write(REG_HIGHEST_STATE, {24'd0, hsc});
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b, eob);
    bytes_sent++;
  endtask

  // drop valid and wait until every expected word is out and the pipe is quiet
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // fill: 0 random, 1 all-zero records, 2 all-ones records with top legal state;
  // cut > 0 truncates the message to that many bytes
  task automatic send_message(input logic [31:0] schema, input logic [31:0] count,
                              input int nrec, input int bad_rec, input int extra,
                              input int cut, input int fill);
    byte_stream_t m;
    logic [95:0] body;
    logic [7:0] st;
    m = {};
    for (int i = 0; i < 4; i++) m = {m, schema[8*i +: 8]};
    for (int i = 0; i < 4; i++) m = {m, count[8*i +: 8]};
    for (int r = 0; r < nrec; r++) begin
      if (fill == 1) body = '0;
      else if (fill == 2) body = '1;
      else body = {$urandom, $urandom, $urandom};
      for (int i = 0; i < 12; i++) m = {m, body[8*i +: 8]};
      if (r == bad_rec && cfg_hsc != 8'hFF) st = 8'($urandom_range(255, int'(cfg_hsc) + 1));
      else if (fill == 1) st = '0;
      else if (fill == 2) st = cfg_hsc;
      else st = 8'($urandom_range(int'(cfg_hsc), 0));
      m = {m, st};
    end
    for (int i = 0; i < extra; i++) m = {m, 8'($urandom)};
    if (cut > 0 && cut < m.size()) m = m[0:cut-1];
    for (int i = 0; i < m.size(); i++) send_byte(m[i], i == m.size() - 1);
  endtask

  // mostly well-formed messages, the rest broken in one way or pure noise
  task automatic random_message();
    int nrec, pick, bad, extra, cut;
    logic [31:0] schema, count;
    nrec = $urandom_range(3);
    if (cfg_max < nrec) nrec = int'(cfg_max);
    schema = cfg_schema;
    count = nrec;
    bad = -1;
    extra = 0;
    cut = 0;
    pick = $urandom_range(99);
    if (pick >= 95) begin
      schema = $urandom;
      count = $urandom_range(3);
      extra = $urandom_range(20);
      cut = $urandom_range(40);
    end else if (pick >= 89) begin
      cut = $urandom_range(1, 7);
    end else if (pick >= 83 && nrec > 0) begin
      cut = $urandom_range(8, 7 + 13 * nrec);
    end else if (pick >= 77) begin
      extra = $urandom_range(1, 20);
    end else if (pick >= 71 && nrec > 0 && cfg_hsc != 8'hFF) begin
      bad = $urandom_range(nrec - 1);
    end else if (pick >= 65 && cfg_max != '1) begin
      count = cfg_max + 1;
    end else if (pick >= 59) begin
      schema = cfg_schema ^ (32'd1 << $urandom_range(31));
    end
    send_message(schema, count, nrec, bad, extra, cut, 0);
  endtask

  task automatic test_directed_messages();
    send_message(1, 0, 0, -1, 0, 1, 0);       // single byte: too short
    send_message(1, 0, 0, -1, 0, 7, 0);       // ends one byte before header end
    send_message(1, 0, 0, -1, 0, 0, 0);       // header only, zero records
    send_message(2, 0, 0, -1, 0, 0, 0);       // schema mismatch at header end
    send_message(1, 65537, 0, -1, 0, 0, 0);   // count above limit
    send_message(1, 65536, 1, -1, 0, 0, 0);   // count at limit, records missing
    send_message(1, 1, 1, -1, 0, 0, 1);       // all-zero record
    send_message(1, 1, 1, -1, 0, 0, 2);       // all-ones record, top legal state
    send_message(1, 3, 3, 1, 0, 0, 0);        // illegal state stops emission
    send_message(1, 1, 1, -1, 5, 0, 0);       // bytes past the last record
    send_message(1, 2, 2, -1, 0, 20, 0);      // ends inside a record
    drain_outputs();
  endtask

  task automatic test_register_access();
    logic [31:0] got;
    reg_read(REG_EXPECTED_SCHEMA, got);
    check_field("expected_schema reset", 32'd1, got);
    reg_read(REG_MAX_RECORD_COUNT, got);
    check_field("max_record_count reset", 32'd65536, got);
    reg_read(REG_HIGHEST_STATE, got);
    check_field("highest_state_code reset", 32'd2, got);
    write_config('1, '1, 8'hFF);
    reg_read(REG_EXPECTED_SCHEMA, got);
    check_field("expected_schema", 32'hFFFF_FFFF, got);
    reg_read(REG_MAX_RECORD_COUNT, got);
    check_field("max_record_count", 32'hFFFF_FFFF, got);
    reg_read(REG_HIGHEST_STATE, got);
    check_field("highest_state_code", 32'h0000_00FF, got);
  endtask

  task automatic test_config_sweep();
    for (int s = 0; s < 3; s++) begin
      drain_outputs();
      if (s == 0) write_config('0, '0, '0);
      else if (s == 1) write_config('1, '1, 8'hFF);
      else write_config($urandom, $urandom_range(1, 4), 8'($urandom_range(1, 254)));
      send_message(cfg_schema, (cfg_max < 2) ? cfg_max : 2, (cfg_max < 2) ? int'(cfg_max) : 2,
                   -1, 0, 0, 2);
    end
    drain_outputs();
  endtask

  task automatic test_backpressure();
    write_config(32'd5, 32'd16, 8'd7);
    // hold the output long enough that the queue fills and input stalls
    rx_hold = 300;
    repeat (2) send_message(32'd5, 32'd3, 3, -1, 0, 0, 0);
    drain_outputs();
  endtask

  task automatic test_idle_phases();
    int start_bytes, start_words;
    int idle_mix[4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{32, 32}};
    write_config($urandom, $urandom_range(2, 6), 8'($urandom_range(1, 254)));
    for (int p = 0; p < 4; p++) begin
      drain_outputs();
      tx_idle_pct = idle_mix[p][0];
      rx_stall_pct = idle_mix[p][1];
      start_bytes = bytes_sent;
      start_words = words_seen;
      while (bytes_sent - start_bytes < 20 || words_seen - start_words < 3)
        random_message();
    end
    drain_outputs();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_messages();
    test_register_access();
    test_config_sweep();
    test_backpressure();
    test_idle_phases();
    drain_outputs();
    repeat (8) @(posedge clk_i);
    $display("covered %0d bytes in %0d messages, %0d output words, %0d records",
             bytes_sent, msgs_sent, words_seen, records_seen);
    $display("message endings: %0d ok, %0d too short, %0d malformed",
             status_tally[ST_OK], status_tally[ST_SHORT], status_tally[ST_BAD]);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("record_stream_deframer_test: done, clean");
    end else begin
      $display("record_stream_deframer_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/rsd_pkg.sv
sv/rsd_cfg_regs.sv
sv/rsd_parser.sv
sv/rsd_out_queue.sv
sv/record_stream_deframer.sv
tb/sv/record_stream_deframer_test.sv
